// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the epoch-to-calendar unit.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/esc_pkg.sv =====
// Package for the epoch-to-calendar unit: microcode word type, step addresses,
// calendar constants, divisor reciprocals and the control store. No dependencies.
package esc_pkg;

  localparam int unsigned STEP_W = 4;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [11:0] MAX_YEAR      = 12'd2106;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // The odd parts of the divisors are 675, 225 and 15 after their powers of two
  // are shifted out; each reciprocal is rounded up and is exact over its input range.
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam logic [25:0] HOUR_RECIP    = 26'd9321;
  localparam logic [25:0] MIN_RECIP     = 26'd1093;

  localparam logic [1:0]  BASE_MOD4     = 2'd2;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;
  localparam logic [8:0]  BASE_MOD400   = 9'd370;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_SETDAY,
    OP_YEAR,
    OP_MONTH,
    OP_SETHOUR,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    dsel_t             dsel;
    cond_t             cond;
    logic [STEP_W-1:0] tgt;
    logic [STEP_W-1:0] seq;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DAYDIV  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SETDAY  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_YEAR    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MONTH   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HOURDIV = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SETHOUR = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MINDIV  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd8;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{OP_LOAD, DSEL_DAY, COND_NO_INPUT, STEP_LOAD, STEP_DAYDIV};
    unique case (step)
      STEP_LOAD:    w = '{OP_LOAD,    DSEL_DAY,  COND_NO_INPUT, STEP_LOAD,
                          STEP_DAYDIV};
      STEP_DAYDIV:  w = '{OP_DIV,     DSEL_DAY,  COND_NEVER,    STEP_LOAD,
                          STEP_SETDAY};
      STEP_SETDAY:  w = '{OP_SETDAY,  DSEL_DAY,  COND_NEVER,    STEP_LOAD,
                          STEP_YEAR};
      STEP_YEAR:    w = '{OP_YEAR,    DSEL_DAY,  COND_MORE,     STEP_YEAR,
                          STEP_MONTH};
      STEP_MONTH:   w = '{OP_MONTH,   DSEL_DAY,  COND_MORE,     STEP_MONTH,
                          STEP_HOURDIV};
      STEP_HOURDIV: w = '{OP_DIV,     DSEL_HOUR, COND_NEVER,    STEP_LOAD,
                          STEP_SETHOUR};
      STEP_SETHOUR: w = '{OP_SETHOUR, DSEL_HOUR, COND_NEVER,    STEP_LOAD,
                          STEP_MINDIV};
      STEP_MINDIV:  w = '{OP_DIV,     DSEL_MIN,  COND_NEVER,    STEP_LOAD,
                          STEP_EMIT};
      STEP_EMIT:    w = '{OP_EMIT,    DSEL_MIN,  COND_OUT_BUSY, STEP_EMIT,
                          STEP_LOAD};
      default:      w = '{OP_LOAD,    DSEL_DAY,  COND_NO_INPUT, STEP_LOAD,
                          STEP_DAYDIV};
    endcase
    return w;
  endfunction

  function automatic logic [16:0] divisor(input dsel_t sel);
    logic [16:0] d;
    d = SECS_PER_DAY;
    unique case (sel)
      DSEL_DAY:  d = SECS_PER_DAY;
      DSEL_HOUR: d = SECS_PER_HOUR;
      DSEL_MIN:  d = SECS_PER_MIN;
      default:   d = SECS_PER_DAY;
    endcase
    return d;
  endfunction

  function automatic logic [25:0] reciprocal(input dsel_t sel);
    logic [25:0] r;
    r = DAY_RECIP;
    unique case (sel)
      DSEL_DAY:  r = DAY_RECIP;
      DSEL_HOUR: r = HOUR_RECIP;
      DSEL_MIN:  r = MIN_RECIP;
      default:   r = DAY_RECIP;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (mon) inside
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/epoch_seconds_to_calendar_unit.sv =====
// Top level of the epoch-to-calendar unit: microcoded sequencer and datapath.
// Depends on esc_pkg and assert_macros.svh.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  epoch_seconds
// out      output     out_valid/out_ready  year, month, day, hour, minute, second
//
// One item at a time; from acceptance to result, a subtract loop takes off one year per cycle,
// then a second loop takes off the months.
// The day, hour and minute splits each take a reciprocal-multiply step and a
// multiply-subtract step. The result waits in an output register; the sequencer is back at its
// load step in the cycle after the write and stalls at its last step only while that register
// is full and out_ready is low. Reset clears the step counter and the output valid flag.
`include "assert_macros.svh"

module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctl_t              ctl;

  logic [31:0]       acc;
  logic [15:0]       quo;
  logic [15:0]       cur_days;
  logic [11:0]       cur_year;
  logic [3:0]        cur_mon;
  logic [4:0]        cur_hour;
  logic [1:0]        y4;
  logic [6:0]        y100;
  logic [8:0]        y400;

  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [24:0]       mul_in;
  logic [50:0]       prod;
  logic [15:0]       quo_calc;
  logic [32:0]       rem_prod;
  logic [31:0]       rem;
  logic              year_more;
  logic              month_more;
  logic              out_free;
  logic              jump;
  logic              emit_fire;

  assign ctl        = ucode(pc);
  assign in_ready   = (ctl.op == OP_LOAD);
  assign out_free   = !out_valid || out_ready;
  assign emit_fire  = (ctl.op == OP_EMIT) && out_free;

  assign leap       = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));
  assign ylen       = leap ? 9'd366 : 9'd365;
  assign mlen       = month_len(cur_mon, leap);
  assign prod       = {26'd0, mul_in} * {25'd0, reciprocal(ctl.dsel)};
  assign rem_prod   = {17'd0, quo} * {16'd0, divisor(ctl.dsel)};
  assign rem        = acc - rem_prod[31:0];
  assign year_more  = cur_days >= {7'd0, ylen};
  assign month_more = (cur_mon != LAST_MONTH) && (cur_days >= {11'd0, mlen});

  always_comb begin
    unique case (ctl.dsel)
      DSEL_DAY:  mul_in = acc[31:7];
      DSEL_HOUR: mul_in = {8'd0, acc[20:4]};
      DSEL_MIN:  mul_in = {6'd0, acc[20:2]};
      default:   mul_in = acc[31:7];
    endcase
  end

  always_comb begin
    unique case (ctl.dsel)
      DSEL_DAY:  quo_calc = prod[50:35];
      DSEL_HOUR: quo_calc = prod[36:21];
      DSEL_MIN:  quo_calc = prod[29:14];
      default:   quo_calc = prod[50:35];
    endcase
  end

  always_comb begin
    case (ctl.cond)
      COND_NO_INPUT: jump = !in_valid;
      COND_MORE:     jump = (ctl.op == OP_YEAR) ? year_more : month_more;
      COND_OUT_BUSY: jump = !out_free;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = jump ? ctl.tgt : ctl.seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_LOAD;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        acc      <= epoch_seconds;
        cur_year <= BASE_YEAR;
        cur_mon  <= 4'd0;
        y4       <= BASE_MOD4;
        y100     <= BASE_MOD100;
        y400     <= BASE_MOD400;
      end
      OP_DIV: begin
        quo <= quo_calc;
      end
      OP_SETDAY: begin
        cur_days <= quo;
        acc      <= rem;
      end
      OP_YEAR: begin
        if (year_more) begin
          cur_days <= cur_days - {7'd0, ylen};
          cur_year <= cur_year + 12'd1;
          y4       <= y4 + 2'd1;
          y100     <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400     <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (month_more) begin
          cur_days <= cur_days - {11'd0, mlen};
          cur_mon  <= cur_mon + 4'd1;
        end
      end
      OP_SETHOUR: begin
        cur_hour <= quo[4:0];
        acc      <= rem;
      end
      OP_EMIT: begin
        if (out_free) begin
          year   <= cur_year;
          month  <= cur_mon + 4'd1;
          day    <= cur_days[4:0] + 5'd1;
          hour   <= cur_hour;
          minute <= quo[5:0];
          second <= rem[5:0];
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, pc == STEP_DAYDIV,
      "accepted item did not start the day division")
  `ASSERT_NEXT(a_emit_returns, emit_fire, out_valid && (pc == STEP_LOAD),
      "result write did not return to the load step")
  `ASSERT_IMPLY(a_month_bound, pc == STEP_MONTH, cur_mon <= LAST_MONTH,
      "month index ran past December")
  `ASSERT_IMPLY(a_year_bound, pc == STEP_YEAR, cur_year <= MAX_YEAR,
      "year loop ran past the largest year")
  `ASSERT_IMPLY(a_emit_ranges, pc == STEP_EMIT, (cur_days < 16'd31) && (rem < 32'd60),
      "day or second out of range at result write")
  `ASSERT_ALWAYS(a_step_valid, pc <= STEP_EMIT, "step counter left the control store")

endmodule
